/* design/tyrg_pkg.sv */
// Shared constants and tables for the target yaw/pitch block.
`timescale 1ns / 1ps
package tyrg_pkg;

    localparam int COORD_WIDTH      = 24;
    localparam int ANGLE_ITERATIONS = 16;

    localparam int HEALTH_W  = 16;
    localparam int MR_W      = 23;
    localparam logic [MR_W-1:0] MR_RESET = 23'd10240;

    // Offset, squared sums and square root widths.
    localparam int D_W      = COORD_WIDTH + 1;
    localparam int FRAC_SH  = 16;
    localparam int SQ_W     = 2 * MR_W + 1;
    localparam int ROOT_W   = (SQ_W + FRAC_SH + 1) / 2;
    localparam int REM_W    = ROOT_W + 2;

    // CORDIC datapath and angle accumulator.
    localparam int CORDIC_W = MR_W + FRAC_SH + 4;
    localparam int ANGLE_W  = 28;
    localparam int ATAN_LEN = 24;

    localparam logic signed [ANGLE_W-1:0] DEG90  = 28'sd5898240;
    localparam logic signed [ANGLE_W-1:0] DEG180 = 28'sd11796480;
    localparam logic signed [ANGLE_W-1:0] DEG360 = 28'sd23592960;
    localparam logic signed [ANGLE_W-1:0] ROUND_HALF = 28'sd256;
    localparam int ROUND_SH = 9;

    localparam int YAW_W   = 16;
    localparam int PITCH_W = 15;
    localparam logic signed [ANGLE_W-1:0] YAW_FULL  = 28'sd46080;
    localparam logic signed [ANGLE_W-1:0] PITCH_MAX = 28'sd11520;

    localparam int S_TDATA_W = ((6 * COORD_WIDTH + HEALTH_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((YAW_W + PITCH_W + 7) / 8) * 8;

    // atan(2^-i) in degrees, Q.16, rounded to nearest.
    localparam logic signed [ANGLE_W-1:0] ATAN_TAB [0:ATAN_LEN-1] = '{
        28'sd2949120, 28'sd1740967, 28'sd919879, 28'sd466945,
        28'sd234379,  28'sd117304,  28'sd58666,  28'sd29335,
        28'sd14668,   28'sd7334,    28'sd3667,   28'sd1833,
        28'sd917,     28'sd458,     28'sd229,    28'sd115,
        28'sd57,      28'sd29,      28'sd14,     28'sd7,
        28'sd4,       28'sd2,       28'sd1,      28'sd0
    };

endpackage

/* design/tyrg_sqrt.sv */
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module tyrg_sqrt (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [tyrg_pkg::SQ_W-1:0]   i_val,
    output logic [tyrg_pkg::ROOT_W-1:0] o_root
);
    import tyrg_pkg::*;

    localparam int V_W = 2 * ROOT_W;

    logic [V_W-1:0]    r_v   [0:ROOT_W-1];
    logic [REM_W-1:0]  r_rem [0:ROOT_W-1];
    logic [ROOT_W-1:0] r_q   [0:ROOT_W-1];

    genvar k;
    generate
        for (k = 0; k < ROOT_W; k++) begin : g_stage
            logic [V_W-1:0]    w_v;
            logic [REM_W-1:0]  w_rem;
            logic [ROOT_W-1:0] w_q;
            logic [REM_W-1:0]  w_sh;
            logic [REM_W-1:0]  w_t;
            if (k == 0) begin : g_first
                assign w_v   = V_W'({i_val, {FRAC_SH{1'b0}}});
                assign w_rem = '0;
                assign w_q   = '0;
            end else begin : g_next
                assign w_v   = r_v[k-1];
                assign w_rem = r_rem[k-1];
                assign w_q   = r_q[k-1];
            end
            assign w_sh = {w_rem[REM_W-3:0], w_v[V_W-1 -: 2]};
            assign w_t  = {w_q, 2'b01};
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_v[k] <= {w_v[V_W-3:0], 2'b00};
                    if (w_sh >= w_t) begin
                        r_rem[k] <= w_sh - w_t;
                        r_q[k]   <= {w_q[ROOT_W-2:0], 1'b1};
                    end else begin
                        r_rem[k] <= w_sh;
                        r_q[k]   <= {w_q[ROOT_W-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    assign o_root = r_q[ROOT_W-1];

endmodule

/* design/tyrg_cordic.sv */
// Pipelined vectoring CORDIC giving atan2(y, x) in Q.16 degrees.
`timescale 1ns / 1ps
module tyrg_cordic (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [tyrg_pkg::CORDIC_W-1:0] i_x,
    input  logic signed [tyrg_pkg::CORDIC_W-1:0] i_y,
    output logic signed [tyrg_pkg::ANGLE_W-1:0]  o_angle
);
    import tyrg_pkg::*;

    localparam int IT = ANGLE_ITERATIONS;

    logic signed [CORDIC_W-1:0] r_x   [0:IT];
    logic signed [CORDIC_W-1:0] r_y   [0:IT];
    logic signed [ANGLE_W-1:0]  r_acc [0:IT];
    logic                       r_fix [0:IT];

    // Axis directions get an exact angle and skip the rotations; a negative x is first turned by 180 degrees.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_y == '0) begin
                r_fix[0] <= 1'b1;
                r_x[0]   <= i_x;
                r_y[0]   <= i_y;
                r_acc[0] <= i_x[CORDIC_W-1] ? DEG180 : '0;
            end else if (i_x == '0) begin
                r_fix[0] <= 1'b1;
                r_x[0]   <= i_x;
                r_y[0]   <= i_y;
                r_acc[0] <= (i_y > 0) ? DEG90 : -DEG90;
            end else if (i_x[CORDIC_W-1]) begin
                r_fix[0] <= 1'b0;
                r_x[0]   <= -i_x;
                r_y[0]   <= -i_y;
                r_acc[0] <= (i_y > 0) ? DEG180 : -DEG180;
            end else begin
                r_fix[0] <= 1'b0;
                r_x[0]   <= i_x;
                r_y[0]   <= i_y;
                r_acc[0] <= '0;
            end
        end
    end

    genvar k;
    generate
        for (k = 0; k < IT; k++) begin : g_iter
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_fix[k+1] <= r_fix[k];
                    if (r_fix[k]) begin
                        r_x[k+1]   <= r_x[k];
                        r_y[k+1]   <= r_y[k];
                        r_acc[k+1] <= r_acc[k];
                    end else if (r_y[k] > 0) begin
                        r_x[k+1]   <= r_x[k] + (r_y[k] >>> k);
                        r_y[k+1]   <= r_y[k] - (r_x[k] >>> k);
                        r_acc[k+1] <= r_acc[k] + ATAN_TAB[k];
                    end else begin
                        r_x[k+1]   <= r_x[k] - (r_y[k] >>> k);
                        r_y[k+1]   <= r_y[k] + (r_x[k] >>> k);
                        r_acc[k+1] <= r_acc[k] - ATAN_TAB[k];
                    end
                end
            end
        end
    endgenerate

    assign o_angle = r_acc[IT];

endmodule

/* design/target_yaw_pitch_with_range_gate.sv */
// Top level: range gate, horizontal distance and yaw/pitch CORDICs.
`timescale 1ns / 1ps
// Each transfer carries observer and target positions and the target health, and
// gives one result: target_ok, yaw in [0,360) and pitch in [-90,90] degrees, Q.7.
// The block takes one item per cycle unless a finished result waits untaken; each
// item passes the offset and range stages, the bit-per-stage square root of the
// horizontal distance, the CORDIC stages and an output register.
// The whole pipeline holds while a finished result is not taken.
// The range register is written through the configuration channel, which is
// always ready, and should only be written while no item is in flight.
module target_yaw_pitch_with_range_gate (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // observer_x, observer_y, observer_z, target_x, target_y, target_z,
    // target_health
    input  logic [tyrg_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // yaw_deg, pitch_deg
    output logic [tyrg_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // target_ok
    output logic                             m_axis_tuser,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [tyrg_pkg::MR_W-1:0]        i_cfg_data
);
    import tyrg_pkg::*;

    localparam int CL = ANGLE_ITERATIONS + 1;

    logic            w_ce;
    logic [MR_W-1:0] r_max_range;

    assign o_cfg_ready   = 1'b1;
    assign w_ce          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_ce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_range <= MR_RESET;
        end else if (i_cfg_valid) begin
            r_max_range <= i_cfg_data;
        end
    end

    // Stage A: offsets and health check.
    logic signed [COORD_WIDTH-1:0] w_ox, w_oy, w_oz, w_tx, w_ty, w_tz;
    logic signed [HEALTH_W-1:0]    w_hp;
    assign w_ox = s_axis_tdata[0*COORD_WIDTH +: COORD_WIDTH];
    assign w_oy = s_axis_tdata[1*COORD_WIDTH +: COORD_WIDTH];
    assign w_oz = s_axis_tdata[2*COORD_WIDTH +: COORD_WIDTH];
    assign w_tx = s_axis_tdata[3*COORD_WIDTH +: COORD_WIDTH];
    assign w_ty = s_axis_tdata[4*COORD_WIDTH +: COORD_WIDTH];
    assign w_tz = s_axis_tdata[5*COORD_WIDTH +: COORD_WIDTH];
    assign w_hp = s_axis_tdata[6*COORD_WIDTH +: HEALTH_W];

    logic                  r_a_vld, r_a_ok;
    logic signed [D_W-1:0] r_a_dx, r_a_dy, r_a_dz;

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_a_ok <= w_hp > 0;
            r_a_dx <= D_W'(w_tx) - D_W'(w_ox);
            r_a_dy <= D_W'(w_ty) - D_W'(w_oy);
            r_a_dz <= D_W'(w_tz) - D_W'(w_oz);
        end
    end

    // Stage B: magnitudes and the per-axis range check.
    logic [D_W-1:0] w_abx, w_aby, w_abz;
    assign w_abx = r_a_dx[D_W-1] ? D_W'(-r_a_dx) : D_W'(r_a_dx);
    assign w_aby = r_a_dy[D_W-1] ? D_W'(-r_a_dy) : D_W'(r_a_dy);
    assign w_abz = r_a_dz[D_W-1] ? D_W'(-r_a_dz) : D_W'(r_a_dz);

    logic                  r_b_vld, r_b_ok;
    logic signed [D_W-1:0] r_b_dx, r_b_dy, r_b_dz;
    logic [MR_W-1:0]       r_b_ax, r_b_ay, r_b_az;

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_b_ok <= r_a_ok && (w_abx <= D_W'(r_max_range))
                             && (w_aby <= D_W'(r_max_range))
                             && (w_abz <= D_W'(r_max_range));
            r_b_ax <= w_abx[MR_W-1:0];
            r_b_ay <= w_aby[MR_W-1:0];
            r_b_az <= w_abz[MR_W-1:0];
            r_b_dx <= r_a_dx;
            r_b_dy <= r_a_dy;
            r_b_dz <= r_a_dz;
        end
    end

    // Stage C: squares.
    logic                  r_c_vld, r_c_ok;
    logic signed [D_W-1:0] r_c_dx, r_c_dy, r_c_dz;
    logic [2*MR_W-1:0]     r_c_ax2, r_c_ay2, r_c_az2, r_c_mr2;

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_c_ok  <= r_b_ok;
            r_c_ax2 <= r_b_ax * r_b_ax;
            r_c_ay2 <= r_b_ay * r_b_ay;
            r_c_az2 <= r_b_az * r_b_az;
            r_c_mr2 <= r_max_range * r_max_range;
            r_c_dx  <= r_b_dx;
            r_c_dy  <= r_b_dy;
            r_c_dz  <= r_b_dz;
        end
    end

    // Stage D: horizontal squared distance.
    logic                  r_d_vld, r_d_ok;
    logic signed [D_W-1:0] r_d_dx, r_d_dy, r_d_dz;
    logic [SQ_W-1:0]       r_d_hsq;
    logic [2*MR_W-1:0]     r_d_ay2, r_d_mr2;

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_d_ok  <= r_c_ok;
            r_d_hsq <= SQ_W'(r_c_ax2) + SQ_W'(r_c_az2);
            r_d_ay2 <= r_c_ay2;
            r_d_mr2 <= r_c_mr2;
            r_d_dx  <= r_c_dx;
            r_d_dy  <= r_c_dy;
            r_d_dz  <= r_c_dz;
        end
    end

    // Stage E: full squared distance against the squared range.
    logic                  r_e_vld, r_e_ok;
    logic signed [D_W-1:0] r_e_dx, r_e_dy, r_e_dz;
    logic [SQ_W-1:0]       r_e_hsq;

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_e_ok  <= r_d_ok && ((SQ_W + 1)'(r_d_hsq) + (SQ_W + 1)'(r_d_ay2)
                                  <= (SQ_W + 1)'(r_d_mr2));
            r_e_hsq <= r_d_hsq;
            r_e_dx  <= r_d_dx;
            r_e_dy  <= r_d_dy;
            r_e_dz  <= r_d_dz;
        end
    end

    // Square root, with the offsets and flags carried alongside.
    logic [ROOT_W-1:0]     w_root;
    logic                  r_s_vld [0:ROOT_W-1];
    logic                  r_s_ok  [0:ROOT_W-1];
    logic signed [D_W-1:0] r_s_dx  [0:ROOT_W-1];
    logic signed [D_W-1:0] r_s_dy  [0:ROOT_W-1];
    logic signed [D_W-1:0] r_s_dz  [0:ROOT_W-1];

    tyrg_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_ce),
        .i_val  (r_e_hsq),
        .o_root (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_s_ok[0] <= r_e_ok;
            r_s_dx[0] <= r_e_dx;
            r_s_dy[0] <= r_e_dy;
            r_s_dz[0] <= r_e_dz;
            for (int k = 1; k < ROOT_W; k++) begin
                r_s_ok[k] <= r_s_ok[k-1];
                r_s_dx[k] <= r_s_dx[k-1];
                r_s_dy[k] <= r_s_dy[k-1];
                r_s_dz[k] <= r_s_dz[k-1];
            end
        end
    end

    // CORDIC operands, scaled by 2^16; the horizontal distance is already Q.8.
    logic signed [CORDIC_W-1:0] w_yaw_x, w_yaw_y, w_pit_x, w_pit_y;
    logic signed [ANGLE_W-1:0]  w_yaw_a, w_pit_a;
    assign w_yaw_x = -(CORDIC_W'(r_s_dx[ROOT_W-1]) <<< FRAC_SH);
    assign w_yaw_y = CORDIC_W'(r_s_dz[ROOT_W-1]) <<< FRAC_SH;
    assign w_pit_y = CORDIC_W'(r_s_dy[ROOT_W-1]) <<< FRAC_SH;
    assign w_pit_x = signed'(CORDIC_W'({w_root, 8'd0}));

    tyrg_cordic u_yaw (
        .i_clk   (i_clk),
        .i_en    (w_ce),
        .i_x     (w_yaw_x),
        .i_y     (w_yaw_y),
        .o_angle (w_yaw_a)
    );

    tyrg_cordic u_pitch (
        .i_clk   (i_clk),
        .i_en    (w_ce),
        .i_x     (w_pit_x),
        .i_y     (w_pit_y),
        .o_angle (w_pit_a)
    );

    logic r_k_vld [0:CL-1];
    logic r_k_ok  [0:CL-1];

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_k_ok[0] <= r_s_ok[ROOT_W-1];
            for (int k = 1; k < CL; k++) begin
                r_k_ok[k] <= r_k_ok[k-1];
            end
        end
    end

    // Valid bits for every stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            for (int k = 0; k < ROOT_W; k++) begin
                r_s_vld[k] <= 1'b0;
            end
            for (int k = 0; k < CL; k++) begin
                r_k_vld[k] <= 1'b0;
            end
        end else if (w_ce) begin
            r_a_vld    <= s_axis_tvalid;
            r_b_vld    <= r_a_vld;
            r_c_vld    <= r_b_vld;
            r_d_vld    <= r_c_vld;
            r_e_vld    <= r_d_vld;
            r_s_vld[0] <= r_e_vld;
            for (int k = 1; k < ROOT_W; k++) begin
                r_s_vld[k] <= r_s_vld[k-1];
            end
            r_k_vld[0] <= r_s_vld[ROOT_W-1];
            for (int k = 1; k < CL; k++) begin
                r_k_vld[k] <= r_k_vld[k-1];
            end
        end
    end

    // Rounding to Q.7, yaw wrap into [0,360) and pitch clamp.
    logic signed [ANGLE_W-1:0] w_yaw_r, w_yaw_f, w_pit_r, w_pit_f;

    always_comb begin
        w_yaw_r = (w_yaw_a + (w_yaw_a[ANGLE_W-1] ? DEG360 : '0) + ROUND_HALF) >>> ROUND_SH;
        if (w_yaw_r >= YAW_FULL) begin
            w_yaw_f = w_yaw_r - YAW_FULL;
        end else if (w_yaw_r[ANGLE_W-1]) begin
            w_yaw_f = '0;
        end else begin
            w_yaw_f = w_yaw_r;
        end
        w_pit_r = (w_pit_a + ROUND_HALF) >>> ROUND_SH;
        if (w_pit_r > PITCH_MAX) begin
            w_pit_f = PITCH_MAX;
        end else if (w_pit_r < -PITCH_MAX) begin
            w_pit_f = -PITCH_MAX;
        end else begin
            w_pit_f = w_pit_r;
        end
    end

    logic                r_o_vld, r_o_ok;
    logic [YAW_W-1:0]    r_o_yaw;
    logic [PITCH_W-1:0]  r_o_pitch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_ce) begin
            r_o_vld <= r_k_vld[CL-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_o_ok    <= r_k_ok[CL-1];
            r_o_yaw   <= r_k_ok[CL-1] ? w_yaw_f[YAW_W-1:0] : '0;
            r_o_pitch <= r_k_ok[CL-1] ? w_pit_f[PITCH_W-1:0] : '0;
        end
    end

    assign m_axis_tvalid = r_o_vld;
    assign m_axis_tuser  = r_o_ok;
    assign m_axis_tdata  = M_TDATA_W'({r_o_pitch, r_o_yaw});

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the target yaw/pitch block with range gate.
`timescale 1ns / 1ps
module testbench;
    import tyrg_pkg::*;

    localparam int SETTLE_CYCLES = 80;
    localparam int STALL_LIMIT   = 5000;

    typedef struct {
        bit                ok;
        logic [YAW_W-1:0]  yaw;
        logic [PITCH_W-1:0] pitch;
    } aim_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic m_axis_tuser;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [MR_W-1:0] i_cfg_data = '0;

    logic [S_TDATA_W-1:0] pending_targets[$];
    aim_t                 expected_aims[$];
    logic [MR_W-1:0]      range_now = MR_RESET;
    int                   errors = 0;
    bit                   steady = 1'b0;
    int                   send_gap = 0;
    int                   take_gap = 0;
    int                   quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    target_yaw_pitch_with_range_gate i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // Vectoring CORDIC in Q.16 degrees, with exact answers on the axes.
    function automatic longint cordic_angle(longint y, longint x);
        longint acc;
        longint nx;
        longint ny;
        acc = 0;
        if (y == 0) return (x < 0) ? longint'(DEG180) : 0;
        if (x == 0) return (y > 0) ? longint'(DEG90) : -longint'(DEG90);
        if (x < 0) begin
            acc = (y > 0) ? longint'(DEG180) : -longint'(DEG180);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < ANGLE_ITERATIONS && i < ATAN_LEN; i++) begin
            if (y > 0) begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                acc += longint'(ATAN_TAB[i]);
            end else begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                acc -= longint'(ATAN_TAB[i]);
            end
            x = nx;
            y = ny;
        end
        return acc;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic aim_t aim_at(logic [S_TDATA_W-1:0] d, logic [MR_W-1:0] rng);
        aim_t r;
        longint dx;
        longint dy;
        longint dz;
        longint mr;
        longint a;
        longint yaw;
        longint pitch;
        longint unsigned hsq;
        longint unsigned hs;
        dx = longint'($signed(d[95:72]))  - longint'($signed(d[23:0]));
        dy = longint'($signed(d[119:96])) - longint'($signed(d[47:24]));
        dz = longint'($signed(d[143:120])) - longint'($signed(d[71:48]));
        mr = longint'(rng);
        r.ok = $signed(d[159:144]) > 0;
        r.yaw = '0;
        r.pitch = '0;
        if (mag(dx) > mr || mag(dy) > mr || mag(dz) > mr) r.ok = 1'b0;
        if (r.ok) begin
            hsq = dx * dx + dz * dz;
            if (hsq + dy * dy > mr * mr) begin
                r.ok = 1'b0;
            end else begin
                a = cordic_angle(dz * 65536, -dx * 65536);
                if (a < 0) a += longint'(DEG360);
                yaw = (a + 256) >>> 9;
                if (yaw >= longint'(YAW_FULL)) yaw -= longint'(YAW_FULL);
                if (yaw < 0) yaw = 0;
                hs = floor_sqrt(hsq << 16);
                a = cordic_angle(dy * 65536, longint'(hs) * 256);
                pitch = (a + 256) >>> 9;
                if (pitch > longint'(PITCH_MAX)) pitch = longint'(PITCH_MAX);
                if (pitch < -longint'(PITCH_MAX)) pitch = -longint'(PITCH_MAX);
                r.yaw = yaw[YAW_W-1:0];
                r.pitch = pitch[PITCH_W-1:0];
            end
        end
        return r;
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_target(int ox, int oy, int oz,
                                                         int tx, int ty, int tz, int hp);
        return {hp[15:0], tz[23:0], ty[23:0], tx[23:0], oz[23:0], oy[23:0], ox[23:0]};
    endfunction

    // Observer anywhere, target placed at a random offset up to span on each axis.
    function automatic logic [S_TDATA_W-1:0] random_target(int span);
        int o[3];
        int off[3];
        int hp;
        for (int k = 0; k < 3; k++) begin
            o[k] = $signed(24'($urandom));
            off[k] = int'($urandom_range(0, 2 * span)) - span;
        end
        hp = ($urandom_range(0, 4) != 0) ? int'($urandom_range(1, 32767))
                                         : int'($signed(16'($urandom)));
        return pack_target(o[0], o[1], o[2], o[0] + off[0], o[1] + off[1], o[2] + off[2], hp);
    endfunction

    function automatic logic [S_TDATA_W-1:0] noise_target();
        return {$urandom, $urandom, $urandom, $urandom, $urandom};
    endfunction

    // Driver: the prediction is made when the transfer happens.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_aims.push_back(aim_at(s_axis_tdata, range_now));
            if (s_axis_tvalid && !s_axis_tready) begin
                // Hold the current item.
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_targets.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= pending_targets.pop_front();
                if (!steady && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 7);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor, with random backpressure outside the steady phase.
    always @(posedge i_clk) begin
        aim_t want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_aims.size() == 0) begin
                    $error("result with no item outstanding");
                    errors++;
                end else begin
                    want = expected_aims.pop_front();
                    if (m_axis_tuser !== want.ok) begin
                        $error("target_ok: expected %0d, got %0d", want.ok, m_axis_tuser);
                        errors++;
                    end
                    if (m_axis_tdata[15:0] !== want.yaw) begin
                        $error("yaw_deg: expected %0d, got %0d", want.yaw, m_axis_tdata[15:0]);
                        errors++;
                    end
                    if (m_axis_tdata[30:16] !== want.pitch) begin
                        $error("pitch_deg: expected %0d, got %0d",
                               $signed(want.pitch), $signed(m_axis_tdata[30:16]));
                        errors++;
                    end
                end
            end
            if (take_gap > 0) begin
                take_gap <= take_gap - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (!steady && $urandom_range(0, 9) == 0) take_gap <= $urandom_range(1, 7);
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic drain();
        while (pending_targets.size() != 0 || s_axis_tvalid || expected_aims.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_range(logic [MR_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        range_now = v;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(int count);
        int span;
        for (int n = 0; n < count; n++) begin
            span = int'(range_now);
            if ($urandom_range(0, 1) == 0) span = span / 2;
            if ($urandom_range(0, 9) == 0) pending_targets.push_back(noise_target());
            else pending_targets.push_back(random_target(span));
        end
    endtask

    initial begin
        logic [MR_W-1:0] ranges[5];
        ranges = '{23'd0, 23'h7FFFFF, 23'd1, 23'd300, MR_W'($urandom)};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items under the reset range of 10240 units.
        pending_targets.push_back(pack_target(0, 0, 0, 0, 0, 0, 1));
        pending_targets.push_back(pack_target(0, 0, 0, 0, 5000, 0, 1));
        pending_targets.push_back(pack_target(0, 0, 0, 0, -5000, 0, 7));
        pending_targets.push_back(pack_target(0, 0, 0, 3000, 0, 0, 10));
        pending_targets.push_back(pack_target(0, 0, 0, -3000, 0, 0, 10));
        pending_targets.push_back(pack_target(0, 0, 0, 0, 0, 3000, 10));
        pending_targets.push_back(pack_target(0, 0, 0, 0, 0, -3000, 10));
        pending_targets.push_back(pack_target(0, 0, 0, -10000, 0, -1, 32767));
        pending_targets.push_back(pack_target(0, 0, 0, 2000, 700, -1500, 5));
        pending_targets.push_back(pack_target(0, 0, 0, 2000, 700, -1500, 0));
        pending_targets.push_back(pack_target(0, 0, 0, 2000, 700, -1500, -1));
        pending_targets.push_back(pack_target(0, 0, 0, 2000, 700, -1500, -32768));
        pending_targets.push_back(pack_target(0, 0, 0, 10241, 0, 0, 5));
        pending_targets.push_back(pack_target(0, 0, 0, 10240, 0, 0, 5));
        pending_targets.push_back(pack_target(0, 0, 0, 6000, 6000, 6000, 5));
        pending_targets.push_back(pack_target(-8388608, -8388608, -8388608,
                                              8388607, 8388607, 8388607, 5));
        pending_targets.push_back(pack_target(8388607, 8388607, 8388607,
                                              8388607, 8388607, 8388607, 5));
        pending_targets.push_back(pack_target(-8388608, 8388607, -8388608,
                                              -8388608, 8388607, -8388600, 5));
        pending_targets.push_back(pack_target(0, 0, 0, 1, 1, 1, 1));
        pending_targets.push_back(pack_target(100, -200, 300, 100, -199, 300, 2));
        random_phase(200);
        drain();

        foreach (ranges[p]) begin
            write_range(ranges[p]);
            if (p == 1) begin
                pending_targets.push_back(pack_target(-8388608, 0, 0, 8388607, 0, 0, 5));
                pending_targets.push_back(pack_target(0, -8388608, 0, 0, 8388607, 0, 5));
                pending_targets.push_back(pack_target(0, 0, 0, -4000000, 3, 4000000, 9));
            end
            if (p == 4) steady = 1'b1;
            random_phase(240);
            drain();
        end

        if (errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
